// ===== rtl/fspm_pkg.sv =====
// Shared types, constants and helpers for the sparsity pattern marker.
package fspm_pkg;

	localparam int DEF_MAX_NODES = 256;
	localparam int DEF_CORNERS   = 8;
	localparam int MAX_CORNERS   = 8;
	localparam int LIW           = $clog2(MAX_CORNERS);
	localparam int CORNER_W      = 8;
	localparam int MAP_W         = 8;
	localparam int NODE_COUNT_W  = 9;
	localparam int INDEX_W       = 9;
	localparam int COUNT_W       = 17;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic signed [INDEX_W-1:0] REDUCED_NONE = '1;

	localparam logic FUNC_NODE    = 1'b0;
	localparam logic FUNC_ELEMENT = 1'b1;

	typedef struct packed {
		logic                func;
		logic                node_fixed;
		logic [CORNER_W-1:0] corner_0;
		logic [CORNER_W-1:0] corner_1;
		logic [CORNER_W-1:0] corner_2;
		logic [CORNER_W-1:0] corner_3;
		logic [CORNER_W-1:0] corner_4;
		logic [CORNER_W-1:0] corner_5;
		logic [CORNER_W-1:0] corner_6;
		logic [CORNER_W-1:0] corner_7;
	} req_t;

	typedef struct packed {
		logic signed [INDEX_W-1:0] reduced_index;
		logic [COUNT_W-1:0]        full_nonzeros;
		logic [COUNT_W-1:0]        reduced_nonzeros;
		logic                      error;
	} result_t;

	typedef logic [MAX_CORNERS-1:0][CORNER_W-1:0] corner_vec_t;

	// One classified request as it passes from the front end to the pattern engine.
	typedef struct packed {
		logic                                 is_elem;
		logic                                 error;
		logic signed [INDEX_W-1:0]            reduced_index;
		corner_vec_t                          corner;
		logic [MAX_CORNERS-1:0]               free;
		logic [MAX_CORNERS-1:0][MAP_W-1:0]    rmap;
	} cmd_t;

	typedef struct packed {
		logic             fixed;
		logic [MAP_W-1:0] rmap;
	} node_info_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_LOOKUP,
		F_PUSH
	} front_state_t;

	function automatic corner_vec_t gather_corners(req_t r);
		corner_vec_t v;
		v[0] = r.corner_0;
		v[1] = r.corner_1;
		v[2] = r.corner_2;
		v[3] = r.corner_3;
		v[4] = r.corner_4;
		v[5] = r.corner_5;
		v[6] = r.corner_6;
		v[7] = r.corner_7;
		return v;
	endfunction

endpackage

// ===== rtl/fspm_front.sv =====
// Front end: takes requests, keeps the node table and looks up each element's corners.
module fspm_front #(
	parameter int MAX_NODES = fspm_pkg::DEF_MAX_NODES,
	parameter int CORNERS   = fspm_pkg::DEF_CORNERS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 accept,
	input  fspm_pkg::req_t                       request,
	input  logic [fspm_pkg::NODE_COUNT_W-1:0]    node_count,
	input  logic                                 queue_full,
	output logic                                 push,
	output fspm_pkg::cmd_t                       push_cmd,
	output logic                                 idle
);
	import fspm_pkg::*;

	localparam int NIW  = $clog2(MAX_NODES);
	localparam int LW   = $clog2(MAX_NODES + 1);
	localparam int CMPW = (LW > NODE_COUNT_W) ? LW : NODE_COUNT_W;
	localparam int CIW  = $clog2(CORNERS);

	front_state_t         state_q, state_d;
	logic [CIW-1:0]       cnt_q;
	logic [LW-1:0]        nodes_loaded_q;
	logic [INDEX_W-1:0]   free_nodes_q;
	cmd_t                 cmd_q;
	cmd_t                 acc_cmd;
	node_info_t           info_q [CORNERS];
	node_info_t           node_mem [MAX_NODES];
	corner_vec_t          corners;
	logic                 node_full;
	logic                 elem_err;
	logic                 node_wr;

	always_comb begin
		corners   = gather_corners(request);
		node_full = (CMPW'(nodes_loaded_q) >= CMPW'(node_count)) ||
		            (CMPW'(nodes_loaded_q) >= CMPW'(MAX_NODES));
		elem_err  = 1'b0;
		for (int k = 0; k < CORNERS; k++) begin
			if (CMPW'(corners[k]) >= CMPW'(nodes_loaded_q)) begin
				elem_err = 1'b1;
			end
		end

		acc_cmd               = '0;
		acc_cmd.is_elem       = request.func;
		acc_cmd.corner        = corners;
		acc_cmd.reduced_index = REDUCED_NONE;
		if (request.func == FUNC_ELEMENT) begin
			acc_cmd.error = elem_err;
		end else begin
			acc_cmd.error = node_full;
			if (!node_full && !request.node_fixed) begin
				acc_cmd.reduced_index = $signed(free_nodes_q);
			end
		end
		node_wr = accept && (request.func == FUNC_NODE) && !node_full;
	end

	// The looked-up corner flags and reduced indices join the request on its way out.
	always_comb begin
		push_cmd = cmd_q;
		push_cmd.free = '0;
		push_cmd.rmap = '0;
		for (int k = 0; k < CORNERS; k++) begin
			push_cmd.free[k] = !info_q[k].fixed;
			push_cmd.rmap[k] = info_q[k].rmap;
		end
	end

	always_comb begin
		state_d = state_q;
		push    = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				if (accept) begin
					state_d = (request.func == FUNC_ELEMENT && !elem_err) ? F_LOOKUP : F_PUSH;
				end
			end
			F_LOOKUP: begin
				if (cnt_q == CIW'(CORNERS - 1)) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				push = !queue_full;
				if (!queue_full) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	assign idle = (state_q == F_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= F_IDLE;
			cnt_q          <= '0;
			nodes_loaded_q <= '0;
			free_nodes_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= '0;
			end else if (state_q == F_LOOKUP) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (node_wr) begin
				nodes_loaded_q <= nodes_loaded_q + LW'(1);
				if (!request.node_fixed) begin
					free_nodes_q <= free_nodes_q + INDEX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= acc_cmd;
		end
	end

	always_ff @(posedge clk) begin
		if (node_wr) begin
			node_mem[NIW'(nodes_loaded_q)] <= '{fixed: request.node_fixed,
			                                    rmap: free_nodes_q[MAP_W-1:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_LOOKUP) begin
			info_q[cnt_q] <= node_mem[NIW'(cmd_q.corner[LIW'(cnt_q)])];
		end
	end

endmodule

// ===== rtl/fspm_queue.sv =====
// Short request queue between the front end and the pattern engine.
module fspm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fspm_pkg::cmd_t  push_cmd,
	input  logic            pop,
	output logic            full,
	output logic            empty,
	output fspm_pkg::cmd_t  head
);
	import fspm_pkg::*;

	localparam int QPW = $clog2(QUEUE_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	cmd_t           entry_q [QUEUE_DEPTH];
	logic [QPW-1:0] wr_ptr_q;
	logic [QPW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;

	assign full  = (count_q == QCW'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	a_q_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("request pushed into a full queue");

	a_q_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("request popped from an empty queue");

endmodule

// ===== rtl/fspm_back.sv =====
// Pattern engine: clears both pattern stores, then marks one element row per cycle while the queue holds requests.
module fspm_back #(
	parameter int MAX_NODES = fspm_pkg::DEF_MAX_NODES,
	parameter int CORNERS   = fspm_pkg::DEF_CORNERS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  fspm_pkg::cmd_t    head,
	output logic              pop,
	output logic              clearing,
	output logic              done,
	output fspm_pkg::result_t result
);
	import fspm_pkg::*;

	// Corner indices never exceed the corner field range, so the stores need no more rows.
	localparam int PAT_N = (MAX_NODES < (1 << CORNER_W)) ? MAX_NODES : (1 << CORNER_W);
	localparam int PIW   = $clog2(PAT_N);
	localparam int CIW   = $clog2(CORNERS);
	localparam int ADDW  = $clog2(CORNERS + 1);

	logic [PAT_N-1:0] full_mem [PAT_N];
	logic [PAT_N-1:0] red_mem  [PAT_N];

	logic               clearing_q;
	logic [PIW-1:0]     clr_q;
	logic [CIW-1:0]     a_q;
	logic               issue, row_op, lane_last;
	logic [PIW-1:0]     rd_row, rd_rrow;

	logic               valid_s2, last_s2, row_op_s2, rfree_s2;
	cmd_t               cmd_s2;
	logic [PIW-1:0]     row_s2, rrow_s2;
	logic [PAT_N-1:0]   rdf_s2, rdr_s2;

	logic               wf_valid_q, wr_valid_q;
	logic [PIW-1:0]     wf_row_q, wr_row_q;
	logic [PAT_N-1:0]   wf_data_q, wr_data_q;

	logic [PAT_N-1:0]   old_f, old_r, new_f, new_r;
	logic [ADDW-1:0]    add_f, add_r;
	logic               wf_en, wr_en;
	logic               first;
	logic [PIW-1:0]     col, rcol;
	logic [COUNT_W-1:0] full_total_q, red_total_q, next_full, next_red;
	logic               done_q;
	result_t            result_q;

	always_comb begin
		issue     = !clearing_q && !q_empty;
		row_op    = head.is_elem && !head.error;
		lane_last = (a_q == CIW'(CORNERS - 1));
		pop       = issue && (!row_op || lane_last);
		rd_row    = PIW'(head.corner[LIW'(a_q)]);
		rd_rrow   = PIW'(head.rmap[LIW'(a_q)]);
	end

	// A row written at the edge that captured this read is still stale in the read data.
	always_comb begin
		old_f = (wf_valid_q && wf_row_q == row_s2) ? wf_data_q : rdf_s2;
		old_r = (wr_valid_q && wr_row_q == rrow_s2) ? wr_data_q : rdr_s2;
		new_f = old_f;
		new_r = old_r;
		add_f = '0;
		add_r = '0;
		for (int b = 0; b < CORNERS; b++) begin
			first = 1'b1;
			for (int p = 0; p < b; p++) begin
				if (cmd_s2.corner[p] == cmd_s2.corner[b]) begin
					first = 1'b0;
				end
			end
			col  = PIW'(cmd_s2.corner[b]);
			rcol = PIW'(cmd_s2.rmap[b]);
			if (first && !old_f[col]) begin
				add_f = add_f + ADDW'(1);
			end
			new_f[col] = 1'b1;
			if (cmd_s2.free[b]) begin
				if (first && !old_r[rcol]) begin
					add_r = add_r + ADDW'(1);
				end
				new_r[rcol] = 1'b1;
			end
		end
		wf_en = valid_s2 && row_op_s2;
		wr_en = wf_en && rfree_s2;
		if (!wr_en) begin
			add_r = '0;
		end
		if (!wf_en) begin
			add_f = '0;
		end
		next_full = full_total_q + COUNT_W'(add_f);
		next_red  = red_total_q + COUNT_W'(add_r);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q   <= 1'b1;
			clr_q        <= '0;
			a_q          <= '0;
			valid_s2     <= 1'b0;
			last_s2      <= 1'b0;
			row_op_s2    <= 1'b0;
			wf_valid_q   <= 1'b0;
			wr_valid_q   <= 1'b0;
			full_total_q <= '0;
			red_total_q  <= '0;
			done_q       <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == PIW'(PAT_N - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (issue && row_op) begin
				a_q <= lane_last ? '0 : a_q + 1'b1;
			end
			valid_s2   <= issue;
			last_s2    <= !row_op || lane_last;
			row_op_s2  <= issue && row_op;
			wf_valid_q <= wf_en;
			wr_valid_q <= wr_en;
			full_total_q <= next_full;
			red_total_q  <= next_red;
			done_q       <= valid_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s2    <= head;
		row_s2    <= rd_row;
		rrow_s2   <= rd_rrow;
		rfree_s2  <= head.free[LIW'(a_q)];
		wf_row_q  <= row_s2;
		wf_data_q <= new_f;
		wr_row_q  <= rrow_s2;
		wr_data_q <= new_r;
		result_q.reduced_index    <= cmd_s2.reduced_index;
		result_q.full_nonzeros    <= next_full;
		result_q.reduced_nonzeros <= next_red;
		result_q.error            <= cmd_s2.error;
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			full_mem[clr_q] <= '0;
		end else if (wf_en) begin
			full_mem[row_s2] <= new_f;
		end
		rdf_s2 <= full_mem[rd_row];
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			red_mem[clr_q] <= '0;
		end else if (wr_en) begin
			red_mem[rrow_s2] <= new_r;
		end
		rdr_s2 <= red_mem[rd_rrow];
	end

	assign clearing = clearing_q;
	assign done     = done_q;
	assign result   = result_q;

	a_bk_idle_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !valid_s2)
		else $error("pattern row processed during the clearing pass");

	a_bk_done_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(valid_s2 && last_s2))
		else $error("result issued without a finished request");

	a_bk_reduced_le_full: assert property (@(posedge clk) disable iff (!arst_n)
		red_total_q <= full_total_q)
		else $error("reduced pattern holds more bits than the full pattern");

endmodule

// ===== rtl/fem_sparsity_pattern_marker.sv =====
// Sparsity pattern marker: top level with the node count register.
// Flow: a node request passes the front end, the queue and the pattern engine; an element
// request also waits for its corner lookups and one engine row per corner.
// The front end makes one node table read per corner and takes a new request once it
// has queued the last one; results are strobed for one cycle and never stall.
// After reset busy stays high while both pattern stores are cleared one row per cycle,
// min(MAX_NODES, 256) rows in all; the node count register resets to zero.
module fem_sparsity_pattern_marker #(
	parameter int MAX_NODES = fspm_pkg::DEF_MAX_NODES,
	parameter int CORNERS   = fspm_pkg::DEF_CORNERS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  fspm_pkg::req_t                    request,
	output logic                              done,
	output fspm_pkg::result_t                 result,
	input  logic                              cfg_we,
	input  logic [fspm_pkg::NODE_COUNT_W-1:0] cfg_wdata
);
	import fspm_pkg::*;

	logic [NODE_COUNT_W-1:0] node_count_q;
	logic                    accept;
	logic                    front_idle;
	logic                    clearing;
	logic                    push, pop, q_full, q_empty;
	cmd_t                    push_cmd, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= '0;
		end else if (cfg_we) begin
			node_count_q <= cfg_wdata;
		end
	end

	assign busy   = clearing || !front_idle;
	assign accept = start && !busy;

	fspm_front #(
		.MAX_NODES (MAX_NODES),
		.CORNERS   (CORNERS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.request    (request),
		.node_count (node_count_q),
		.queue_full (q_full),
		.push       (push),
		.push_cmd   (push_cmd),
		.idle       (front_idle)
	);

	fspm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (head)
	);

	fspm_back #(
		.MAX_NODES (MAX_NODES),
		.CORNERS   (CORNERS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.head     (head),
		.pop      (pop),
		.clearing (clearing),
		.done     (done),
		.result   (result)
	);

endmodule
